// ===== sv/tcw_pkg.sv =====
// types, constants and sizes shared by the text console writer files
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_LEN   = (ROWS - 1) * COLUMNS;

  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int RAM_AW  = $clog2(CELL_COUNT);
  localparam int ADDR_W  = 11;
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } tcw_state_e;

  typedef struct packed {
    logic idle;
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic wr_clear;
    logic wr_copy;
    logic wr_fill;
    logic rd_copy;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic scroll_needed;
    logic cnt_zero;
    logic cnt_copy_end;
    logic cnt_last;
    logic out_free;
  } tcw_status_t;

endpackage

// ===== sv/tcw_if.sv =====
// request, result and color register channels of the text console writer
interface tcw_in_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [CHAR_W-1:0]   char_code;
  logic [ADDR_W-1:0]   cell_address;

  modport source (output valid, command, char_code, cell_address, input ready);
  modport sink   (input valid, command, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   cursor_position;
  logic [CELL_W-1:0]   cell_value;
  logic                scrolled;

  modport source (output valid, cursor_position, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_value, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  text_color;

  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

// ===== sv/tcw_ram.sv =====
// generic single write port, single read port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcw_ctrl.sv =====
// controller state machine: clear pass, request accept, scroll copy and fill
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t    cmd_o
);
  import tcw_pkg::*;

  tcw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.scroll_needed ? ST_COPY : ST_FINISH;
        end
      end
      ST_COPY: begin
        if (status_i.cnt_copy_end) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.cnt_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.cnt_inc  = !status_i.cnt_last;
        cmd_o.cnt_clr  = status_i.cnt_last;
      end
      ST_IDLE: begin
        cmd_o.idle    = 1'b1;
        cmd_o.accept  = in_valid_i;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_COPY: begin
        // read runs one cell ahead of the write
        cmd_o.rd_copy = !status_i.cnt_copy_end;
        cmd_o.wr_copy = !status_i.cnt_zero;
        cmd_o.cnt_inc = !status_i.cnt_copy_end;
      end
      ST_FILL: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.cnt_inc = !status_i.cnt_last;
        cmd_o.cnt_clr = status_i.cnt_last;
      end
      ST_FINISH: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/tcw_datapath.sv =====
// datapath: cell store, cursor, color register, sweep counter, result register
module tcw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::tcw_cmd_t             cmd_i,
  output tcw_pkg::tcw_status_t          status_o,
  input  logic                          command_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_address_i,
  input  logic                          cfg_valid_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_color_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_position_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value_o,
  output logic                          scrolled_o
);
  import tcw_pkg::*;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [COLOR_W-1:0] color_q;
  logic [RAM_AW-1:0]  cnt_q;
  logic               is_read_q, oor_q, scrolled_q;
  logic               out_valid_q;
  logic [ADDR_W-1:0]  pos_q;
  logic [CELL_W-1:0]  cell_q;
  logic               out_scrolled_q;

  logic               put, is_nl, wrap, last_row, oor;
  logic [RAM_AW-1:0]  cursor_lin;
  logic               we, re;
  logic [RAM_AW-1:0]  waddr, raddr;
  logic [CELL_W-1:0]  wdata, rdata;

  assign put        = cmd_i.accept && (command_i == CMD_PUT);
  assign is_nl      = (char_code_i == NEWLINE_CODE);
  assign wrap       = is_nl || (col_q == COL_W'(COLUMNS - 1));
  assign last_row   = (row_q == ROW_W'(ROWS - 1));
  assign oor        = 32'(cell_address_i) >= 32'(CELL_COUNT);
  assign cursor_lin = RAM_AW'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));

  assign status_o.scroll_needed = (command_i == CMD_PUT) && wrap && last_row;
  assign status_o.cnt_zero      = (cnt_q == '0);
  assign status_o.cnt_copy_end  = (cnt_q == RAM_AW'(COPY_LEN));
  assign status_o.cnt_last      = (cnt_q == RAM_AW'(CELL_COUNT - 1));
  assign status_o.out_free      = !out_valid_q || out_ready_i;

  // cursor advance on a put; the bottom row stays put when it would scroll
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (put) begin
      if (wrap) begin
        col_d = '0;
        if (!last_row) row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = {RESET_COLOR, BLANK_CODE};
    if (cmd_i.wr_clear) begin
      we = 1'b1;
    end else if (cmd_i.wr_copy) begin
      we    = 1'b1;
      waddr = cnt_q - 1'b1;
      wdata = rdata;
    end else if (cmd_i.wr_fill) begin
      we    = 1'b1;
      wdata = {color_q, BLANK_CODE};
    end else if (put && !is_nl) begin
      we    = 1'b1;
      waddr = cursor_lin;
      wdata = {color_q, char_code_i};
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = RAM_AW'(32'(cnt_q) + 32'(COLUMNS));
    if (cmd_i.rd_copy) begin
      re = 1'b1;
    end else if (cmd_i.accept && (command_i == CMD_READ) && !oor) begin
      re    = 1'b1;
      raddr = RAM_AW'(cell_address_i);
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      color_q     <= RESET_COLOR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cfg_valid_i) color_q <= cfg_color_i;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_read_q  <= (command_i == CMD_READ);
      oor_q      <= oor;
      scrolled_q <= status_o.scroll_needed;
    end
    if (cmd_i.out_load) begin
      pos_q          <= ADDR_W'(cursor_lin);
      cell_q         <= (is_read_q && !oor_q) ? rdata : '0;
      out_scrolled_q <= scrolled_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_q;
  assign cell_value_o      = cell_q;
  assign scrolled_o        = out_scrolled_q;

endmodule

// ===== sv/text_console_char_writer.sv =====
// top level of the teletype character writer over the text cell store
//
// Requests arrive on in_ch: command 0 puts char_code at the cursor (a newline
// only moves the cursor), command 1 reads the cell at cell_address. Every
// request gives exactly one result on out_ch: the cursor position after the
// request, the cell read (zero for a put or an address past the store) and
// a flag that marks a put that scrolled the screen.
// cfg_ch writes the attribute byte used for puts and for blank rows; it is
// always ready and takes effect at the next request.
// A request is accepted in ST_IDLE, and its result is loaded into the output
// register in ST_FINISH once that register is free; a read takes its cell
// from the registered read port of the single cell ram. A put that scrolls
// copies 24 rows through the one read and one write port and blanks the
// bottom row in ST_COPY and ST_FILL before its result is loaded.
// After reset the store is cleared to blank grey on black in a pass over all
// ROWS*COLUMNS cells during which no request is accepted.
// A finished result waits in the output register while a new request is
// accepted; a stalled receiver holds the block before its next result.
module text_console_char_writer (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcw_in_if.sink   in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink  cfg_ch
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  assign in_ch.ready  = cmd.idle;
  assign cfg_ch.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .command_i         (in_ch.command),
    .char_code_i       (in_ch.char_code),
    .cell_address_i    (in_ch.cell_address),
    .cfg_valid_i       (cfg_ch.valid),
    .cfg_color_i       (cfg_ch.text_color),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .cursor_position_o (out_ch.cursor_position),
    .cell_value_o      (out_ch.cell_value),
    .scrolled_o        (out_ch.scrolled)
  );

endmodule
